### rtl/cmap_pkg.sv
// Shared types and constants for the piecewise-linear color map.
// Used by every module of the block; no dependencies.
package cmap_pkg;

    localparam int VALUE_BITS = 16;
    localparam int MAX_POINTS = 7;
    localparam int CHANNELS   = 3;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int PORT_BITS  = 16;
    localparam int CFG_BITS   = 64;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [VALUE_BITS-1:0] FULL_SCALE = {VALUE_BITS{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_FIRST = 3'd1;

    // Field offsets inside a control point word
    localparam int POS_LSB   = 48;
    localparam int RED_LSB   = 32;
    localparam int GREEN_LSB = 16;
    localparam int BLUE_LSB  = 0;

    typedef logic [VALUE_BITS-1:0] val_t;

    // One classified item: base color, span to the next color, direction,
    // and the fraction num/den to apply to the span.
    typedef struct packed {
        val_t [CHANNELS-1:0] base;
        val_t [CHANNELS-1:0] span;
        logic [CHANNELS-1:0] neg;
        val_t                num;
        val_t                den;
    } job_t;

    typedef struct packed {
        val_t [CHANNELS-1:0] color;
    } pixel_t;

endpackage

### rtl/cmap_front.sv
// Front end: configuration registers, segment search and operand setup.
// Depends on cmap_pkg.
module cmap_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [cmap_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cmap_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic [cmap_pkg::PORT_BITS-1:0]    intensity,
    output cmap_pkg::job_t                    job
);
    import cmap_pkg::*;

    logic [CNT_BITS-1:0] count_reg;
    logic [CFG_BITS-1:0] point_reg [MAX_POINTS];

    val_t                 x;
    val_t                 pos [MAX_POINTS];
    val_t [CHANNELS-1:0]  col [MAX_POINTS];
    logic [CNT_BITS-1:0]  ne;
    logic [CNT_BITS-1:0]  j;
    logic [IDX_BITS-1:0]  lo;
    logic [IDX_BITS-1:0]  hi;
    logic [IDX_BITS-1:0]  last;
    logic [MAX_POINTS-1:0] hit;
    logic [CFG_IDX_BITS-1:0] slot;

    assign slot = cfg_index - REG_POINT_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_POINT_COUNT)
            begin
                count_reg <= CNT_BITS'(cfg_data[2:0]);
            end
            else if (int'(slot) < MAX_POINTS)
            begin
                point_reg[IDX_BITS'(slot)] <= cfg_data;
            end
        end
    end

    always_comb
    begin
        x = intensity[VALUE_BITS-1:0];
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            pos[i]    = point_reg[i][POS_LSB +: VALUE_BITS];
            col[i][0] = point_reg[i][RED_LSB +: VALUE_BITS];
            col[i][1] = point_reg[i][GREEN_LSB +: VALUE_BITS];
            col[i][2] = point_reg[i][BLUE_LSB +: VALUE_BITS];
        end
        if (int'(count_reg) > MAX_POINTS)
        begin
            ne = CNT_BITS'(MAX_POINTS);
        end
        else
        begin
            ne = count_reg;
        end
        // Default grey ramp and single-point constant both use two points
        if (ne == '0)
        begin
            pos[0] = '0;
            pos[1] = FULL_SCALE;
            col[0] = '0;
            col[1] = {CHANNELS{FULL_SCALE}};
            ne     = CNT_BITS'(2);
        end
        else if (ne == CNT_BITS'(1))
        begin
            pos[1] = pos[0];
            col[1] = col[0];
            ne     = CNT_BITS'(2);
        end

        for (int i = 0; i < MAX_POINTS; i++)
        begin
            hit[i] = (i < int'(ne)) && (pos[i] >= x);
        end
        j = ne;
        for (int i = MAX_POINTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                j = CNT_BITS'(i);
            end
        end

        lo   = IDX_BITS'(j - 1'b1);
        hi   = IDX_BITS'(j);
        last = IDX_BITS'(ne - 1'b1);

        job.span = '0;
        job.neg  = '0;
        job.num  = '0;
        job.den  = VALUE_BITS'(1);
        if (j == '0)
        begin
            job.base = col[0];
        end
        else if (j == ne)
        begin
            job.base = col[last];
        end
        else
        begin
            job.base = col[lo];
            job.num  = x - pos[lo];
            job.den  = pos[hi] - pos[lo];
            for (int k = 0; k < CHANNELS; k++)
            begin
                job.neg[k] = col[hi][k] < col[lo][k];
                job.span[k] = job.neg[k] ? (col[lo][k] - col[hi][k])
                                         : (col[hi][k] - col[lo][k]);
            end
        end
    end

endmodule

### rtl/cmap_queue.sv
// Short queue of classified items between front and back end.
// Depends on cmap_pkg.
module cmap_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cmap_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output cmap_pkg::job_t rdata,
    output logic           empty
);
    import cmap_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    job_t                mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [PTR_BITS:0]   cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (cnt_reg == (PTR_BITS+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

### rtl/cmap_back.sv
// Back end: multiply, bit-per-stage division pipeline and result queue.
// Depends on cmap_pkg.
module cmap_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cmap_pkg::job_t in_job,
    output logic           in_take,
    output logic           empty,
    input  logic           pop,
    output cmap_pkg::pixel_t result
);
    import cmap_pkg::*;

    localparam int OUT_DEPTH = 32;
    localparam int OPTR_BITS = $clog2(OUT_DEPTH);
    localparam int OCC_BITS  = $clog2(OUT_DEPTH + 1);
    localparam int STAGES    = VALUE_BITS + 1;

    typedef struct packed {
        val_t [CHANNELS-1:0] base;
        logic [CHANNELS-1:0] neg;
        val_t                den;
        val_t [CHANNELS-1:0] rem;
        val_t [CHANNELS-1:0] low;
        val_t [CHANNELS-1:0] quo;
    } div_t;

    div_t                st_reg  [STAGES];
    div_t                st_next [STAGES];
    logic [STAGES-1:0]   vld_reg;
    logic [2*VALUE_BITS-1:0] prod [CHANNELS];
    logic [VALUE_BITS:0] trial;
    logic [VALUE_BITS:0] dext;

    pixel_t               fifo_reg [OUT_DEPTH];
    pixel_t               done;
    logic [OPTR_BITS-1:0] wr_reg, rd_reg;
    logic [OPTR_BITS:0]   cnt_reg;
    logic [OCC_BITS-1:0]  occ_reg, occ_next;
    logic                 do_pop;
    logic                 do_write;

    // Issue only with a free result slot reserved for the item
    assign in_take  = in_valid && (int'(occ_reg) < OUT_DEPTH);
    assign empty    = (cnt_reg == '0);
    assign do_pop   = pop && !empty;
    assign do_write = vld_reg[STAGES-1];
    assign result   = fifo_reg[rd_reg];

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            prod[k] = in_job.num * in_job.span[k];
        end
        st_next[0].base = in_job.base;
        st_next[0].neg  = in_job.neg;
        st_next[0].den  = in_job.den;
        for (int k = 0; k < CHANNELS; k++)
        begin
            // High half is below den because the quotient fits VALUE_BITS
            st_next[0].rem[k] = prod[k][2*VALUE_BITS-1:VALUE_BITS];
            st_next[0].low[k] = prod[k][VALUE_BITS-1:0];
            st_next[0].quo[k] = '0;
        end
        trial = '0;
        dext  = '0;
        for (int s = 1; s < STAGES; s++)
        begin
            st_next[s] = st_reg[s-1];
            dext = {1'b0, st_reg[s-1].den};
            for (int k = 0; k < CHANNELS; k++)
            begin
                trial = {st_reg[s-1].rem[k], st_reg[s-1].low[k][VALUE_BITS-1]};
                st_next[s].low[k] = st_reg[s-1].low[k] << 1;
                if (trial >= dext)
                begin
                    st_next[s].rem[k] = VALUE_BITS'(trial - dext);
                    st_next[s].quo[k] = {st_reg[s-1].quo[k][VALUE_BITS-2:0], 1'b1};
                end
                else
                begin
                    st_next[s].rem[k] = trial[VALUE_BITS-1:0];
                    st_next[s].quo[k] = {st_reg[s-1].quo[k][VALUE_BITS-2:0], 1'b0};
                end
            end
        end
        for (int k = 0; k < CHANNELS; k++)
        begin
            done.color[k] = st_reg[STAGES-1].neg[k]
                          ? st_reg[STAGES-1].base[k] - st_reg[STAGES-1].quo[k]
                          : st_reg[STAGES-1].base[k] + st_reg[STAGES-1].quo[k];
        end
        occ_next = occ_reg + OCC_BITS'(in_take) - OCC_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            occ_reg <= '0;
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_take};
            occ_reg <= occ_next;
            if (do_write)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (OPTR_BITS+1)'(do_write) - (OPTR_BITS+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            st_reg[s] <= st_next[s];
        end
        if (do_write)
        begin
            fifo_reg[wr_reg] <= done;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= OUT_DEPTH)
        else $error("result credit count overflow");

    a_fifo_within_occ: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) + $countones(vld_reg) == int'(occ_reg))
        else $error("in-flight items and credit count disagree");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |-> (int'(cnt_reg) < OUT_DEPTH || do_pop))
        else $error("result queue written while full");

endmodule

### rtl/piecewise_linear_color_map.sv
// Top level of the piecewise-linear color map: front end, job queue, back end.
// Depends on cmap_pkg, cmap_front, cmap_queue, cmap_back.
//
// Maps a 16-bit intensity to a 16-bit RGB color by linear interpolation between
// up to seven configured control points (count 0 gives a black-to-white ramp,
// count 1 a constant color). The block takes one intensity per clock while
// full is low and gives one color per clock while empty is low and pop is
// high; a result passes through the job queue with the multiply at its output,
// sixteen one-bit divider stages and a registered write into the result queue.
// The 32-entry result queue holds every item in flight, so push may keep going
// while pop is held low until 36 items wait. Write the configuration only while
// no item is in flight.
module piecewise_linear_color_map (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [cmap_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cmap_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [cmap_pkg::PORT_BITS-1:0]    intensity,
    output logic                              empty,
    input  logic                              pop,
    output logic [cmap_pkg::PORT_BITS-1:0]    red,
    output logic [cmap_pkg::PORT_BITS-1:0]    green,
    output logic [cmap_pkg::PORT_BITS-1:0]    blue
);
    import cmap_pkg::*;

    job_t   front_job;
    job_t   head_job;
    logic   q_empty;
    logic   take;
    pixel_t result;

    cmap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .intensity (intensity),
        .job       (front_job)
    );

    cmap_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_job),
        .full  (full),
        .pop   (take),
        .rdata (head_job),
        .empty (q_empty)
    );

    cmap_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_job   (head_job),
        .in_take  (take),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    assign red   = PORT_BITS'(result.color[0]);
    assign green = PORT_BITS'(result.color[1]);
    assign blue  = PORT_BITS'(result.color[2]);

endmodule

### bench/tb_piecewise_linear_color_map.sv
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise-linear color map.
// Depends on cmap_pkg and piecewise_linear_color_map; predicts colors in-bench.
module tb_piecewise_linear_color_map;
    import cmap_pkg::*;

    localparam int CHECK_LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } color_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;
    logic push;
    logic full;
    logic [PORT_BITS-1:0] intensity;
    logic empty;
    logic pop;
    logic [PORT_BITS-1:0] red;
    logic [PORT_BITS-1:0] green;
    logic [PORT_BITS-1:0] blue;

    // Shadow copy of the configuration
    logic [2:0] shadow_count;
    logic [63:0] shadow_point [MAX_POINTS];

    color_t expected_colors [$];
    int errors;
    int items_sent;
    int colors_seen;
    int idle_cycles;
    bit hold_pop;
    bit bursty_pop;

    piecewise_linear_color_map dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .push(push), .full(full), .intensity(intensity),
        .empty(empty), .pop(pop), .red(red), .green(green), .blue(blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] blend_channel(logic [15:0] c0, logic [15:0] c1,
                                                  logic [15:0] num, logic [15:0] den);
        logic [31:0] q;
        if (c1 >= c0)
        begin
            q = (32'(num) * 32'(c1 - c0)) / 32'(den);
            return c0 + q[15:0];
        end
        q = (32'(num) * 32'(c0 - c1)) / 32'(den);
        return c0 - q[15:0];
    endfunction

    function automatic color_t map_color(logic [15:0] x);
        logic [15:0] pos [MAX_POINTS];
        color_t col [MAX_POINTS];
        int n;
        int j;
        color_t res;
        n = shadow_count;
        if (n == 0)
        begin
            pos[0] = 16'h0000;
            pos[1] = FULL_SCALE;
            col[0] = '0;
            col[1] = {FULL_SCALE, FULL_SCALE, FULL_SCALE};
            n = 2;
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                pos[i] = shadow_point[i][POS_LSB +: 16];
                col[i] = {shadow_point[i][RED_LSB +: 16], shadow_point[i][GREEN_LSB +: 16],
                          shadow_point[i][BLUE_LSB +: 16]};
            end
            if (n == 1)
            begin
                pos[1] = pos[0];
                col[1] = col[0];
                n = 2;
            end
        end
        j = 0;
        while (j < n && pos[j] < x)
            j++;
        if (j == 0)
            return col[0];
        if (j == n)
            return col[n-1];
        res.r = blend_channel(col[j-1].r, col[j].r, x - pos[j-1], pos[j] - pos[j-1]);
        res.g = blend_channel(col[j-1].g, col[j].g, x - pos[j-1], pos[j] - pos[j-1]);
        res.b = blend_channel(col[j-1].b, col[j].b, x - pos[j-1], pos[j] - pos[j-1]);
        return res;
    endfunction

    // One write, then a quiet gap with cfg_write low so back-to-back writes never overlap
    task automatic write_reg(int idx, logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_BITS'(idx);
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == int'(REG_POINT_COUNT))
            shadow_count = value[2:0];
        else
            shadow_point[idx - int'(REG_POINT_FIRST)] = value;
        @(posedge clk);
    endtask

    task automatic drain;
        push <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (CHECK_LATENCY) @(posedge clk);
    endtask

    task automatic send_intensity(logic [15:0] x, bit with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        intensity <= x;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_colors.insert(expected_colors.size(), map_color(x));
        items_sent++;
    endtask

    function automatic logic [63:0] rand_point(logic [15:0] pos);
        return {pos, 16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // Random positions, sorted when asked, sometimes with repeats or extremes
    task automatic load_random_points(int count, bit sorted);
        logic [15:0] p [MAX_POINTS];
        logic [15:0] t;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            case ($urandom_range(0, 5))
                0: p[i] = 16'h0000;
                1: p[i] = 16'hFFFF;
                default: p[i] = 16'($urandom);
            endcase
            if (i > 0 && $urandom_range(0, 6) == 0)
                p[i] = p[i-1];
        end
        if (sorted)
            for (int i = 0; i < MAX_POINTS; i++)
                for (int k = i + 1; k < MAX_POINTS; k++)
                    if (p[k] < p[i])
                    begin
                        t = p[i];
                        p[i] = p[k];
                        p[k] = t;
                    end
        for (int i = 0; i < MAX_POINTS; i++)
            write_reg(REG_POINT_FIRST + i, rand_point(p[i]));
        write_reg(REG_POINT_COUNT, 64'(count));
    endtask

    function automatic logic [15:0] rand_intensity();
        int i;
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2:
            begin
                i = $urandom_range(0, MAX_POINTS - 1);
                return shadow_point[i][POS_LSB +: 16] + 16'($urandom_range(0, 2)) - 16'd1;
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_default_ramp;
        send_intensity(16'h0000, 0);
        send_intensity(16'hFFFF, 0);
        send_intensity(16'h8000, 0);
        send_intensity(16'h0001, 0);
        send_intensity(16'h5555, 0);
        send_intensity(16'hAAAA, 0);
        drain();
    endtask

    task automatic test_directed_points;
        write_reg(REG_POINT_FIRST + 0, {16'h1000, 16'hFFFF, 16'h0000, 16'h1234});
        write_reg(REG_POINT_FIRST + 1, {16'h8000, 16'h0000, 16'hFFFF, 16'h1234});
        write_reg(REG_POINT_FIRST + 2, {16'h8000, 16'h5555, 16'hAAAA, 16'hFFFF});
        write_reg(REG_POINT_FIRST + 3, {16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
        write_reg(REG_POINT_FIRST + 4, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        write_reg(REG_POINT_FIRST + 5, {16'hFFFF, 16'h1111, 16'h2222, 16'h3333});
        write_reg(REG_POINT_FIRST + 6, {16'hFFFF, 16'h4444, 16'h5555, 16'h6666});
        write_reg(REG_POINT_COUNT, 64'd1);
        send_intensity(16'h0000, 0);
        send_intensity(16'hFFFF, 0);
        drain();
        write_reg(REG_POINT_COUNT, 64'd7);
        // below first, on a point, between, on a repeated position, at the top
        send_intensity(16'h0000, 0);
        send_intensity(16'h1000, 0);
        send_intensity(16'h1001, 0);
        send_intensity(16'h4000, 0);
        send_intensity(16'h8000, 0);
        send_intensity(16'h8001, 0);
        send_intensity(16'hFFFE, 0);
        send_intensity(16'hFFFF, 0);
        drain();
        // unordered positions
        write_reg(REG_POINT_FIRST + 1, {16'h0800, 16'h0000, 16'hFFFF, 16'h1234});
        write_reg(REG_POINT_COUNT, 64'd3);
        send_intensity(16'h0C00, 0);
        send_intensity(16'h9000, 0);
        send_intensity(16'hFFFF, 0);
        drain();
    endtask

    task automatic test_random_configs(int rounds, int per_round);
        for (int r = 0; r < rounds; r++)
        begin
            load_random_points($urandom_range(0, 7), $urandom_range(0, 4) != 0);
            for (int i = 0; i < per_round; i++)
                send_intensity(rand_intensity(), (r % 3) != 2);
            drain();
        end
    endtask

    task automatic test_backpressure;
        load_random_points(7, 1);
        hold_pop = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_pop = 1'b0;
            end
            for (int i = 0; i < 100; i++)
                send_intensity(rand_intensity(), 0);
        join
        drain();
    endtask

    // Consumer: random pop stalls, and pop held low while hold_pop is set
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = bursty_pop ? $urandom_range(0, 16) : 0;
            if ($urandom_range(0, 2) == 0)
                stall = 0;
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            if (hold_pop)
            begin
                pop <= 1'b0;
                while (hold_pop)
                    @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty && !hold_pop)
                @(posedge clk);
        end
    end

    // Checker: compare each transfer out with the oldest expectation
    always @(posedge clk)
    begin
        color_t want;
        if (rst_n && pop && !empty)
        begin
            colors_seen++;
            if (expected_colors.size() == 0)
            begin
                $error("unexpected color r=%h g=%h b=%h", red, green, blue);
                errors++;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (red !== want.r)
                begin
                    $error("red: expected %h, actual %h", want.r, red);
                    errors++;
                end
                if (green !== want.g)
                begin
                    $error("green: expected %h, actual %h", want.g, green);
                    errors++;
                end
                if (blue !== want.b)
                begin
                    $error("blue: expected %h, actual %h", want.b, blue);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer and no configuration write
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        items_sent = 0;
        colors_seen = 0;
        hold_pop = 1'b0;
        bursty_pop = 1'b1;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        intensity = '0;
        shadow_count = '0;
        for (int i = 0; i < MAX_POINTS; i++)
            shadow_point[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_ramp();
        test_directed_points();
        test_random_configs(20, 40);
        bursty_pop = 1'b0;
        test_random_configs(4, 60);
        bursty_pop = 1'b1;
        test_backpressure();
        test_random_configs(4, 30);
        $display("Sent %0d intensities over default, single, sorted and unordered point sets;",
                 items_sent);
        $display("checked %0d colors, including a long result-side stall.", colors_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### filelist.f
rtl/cmap_pkg.sv
rtl/cmap_front.sv
rtl/cmap_queue.sv
rtl/cmap_back.sv
rtl/piecewise_linear_color_map.sv
bench/tb_piecewise_linear_color_map.sv
